[hdl/kdcar_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key click decoder package
// Shared payload types, register indexes and reset values.
// ----------------------------------------------------------------------------
package kdcar_pkg;

  localparam int unsigned ELAPSED_W = 9;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_REPEAT_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL      = 2'd2;

  localparam int unsigned RST_DOUBLE_CLICK_WINDOW  = 30;
  localparam int unsigned RST_INITIAL_REPEAT_DELAY = 50;
  localparam int unsigned RST_REPEAT_INTERVAL      = 10;

  typedef struct packed {
    logic key1_down;
    logic key2_down;
    logic key3_short_press;
    logic key4_short_press;
  } tick_t;

  typedef struct packed {
    logic key1_fire;
    logic key2_fire;
    logic key3_single_click;
    logic key3_double_click;
    logic key4_single_click;
    logic key4_double_click;
    logic any_event;
  } result_t;

endpackage

[hdl/kdcar_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key click decoder stream channel
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface kdcar_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hdl/kdcar_click.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key click decoder: click detector
// Tells single from double clicks of one short-press key.
// ----------------------------------------------------------------------------
module kdcar_click #(
  parameter int unsigned DELAY_WIDTH = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   press_i,
  input  logic [DELAY_WIDTH-1:0] window_i,
  output logic                   single_o,
  output logic                   double_o
);

  localparam int unsigned CMP_W =
    (DELAY_WIDTH > kdcar_pkg::ELAPSED_W) ? DELAY_WIDTH : kdcar_pkg::ELAPSED_W;

  logic                          waiting_q, waiting_d;
  logic [kdcar_pkg::ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic [kdcar_pkg::ELAPSED_W-1:0] elapsed_inc;
  logic                          expire;
  logic                          still_waiting;

  always_comb begin
    elapsed_inc = elapsed_q;
    if (waiting_q && (elapsed_q != kdcar_pkg::ELAPSED_MAX)) begin
      elapsed_inc = elapsed_q + 1'b1;
    end
    expire        = waiting_q && (CMP_W'(elapsed_inc) > CMP_W'(window_i));
    still_waiting = waiting_q && !expire;

    single_o  = expire;
    double_o  = 1'b0;
    waiting_d = still_waiting;
    elapsed_d = elapsed_inc;
    if (press_i) begin
      if (still_waiting) begin
        double_o  = 1'b1;
        waiting_d = 1'b0;
      end else begin
        waiting_d = 1'b1;
        elapsed_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q <= 1'b0;
      elapsed_q <= '0;
    end else if (step_i) begin
      waiting_q <= waiting_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

[hdl/kdcar_repeat.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key click decoder: auto-repeat
// Fires on press, after the initial delay, then every repeat interval.
// ----------------------------------------------------------------------------
module kdcar_repeat #(
  parameter int unsigned DELAY_WIDTH = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   down_i,
  input  logic [DELAY_WIDTH-1:0] initial_delay_i,
  input  logic [DELAY_WIDTH-1:0] interval_i,
  output logic                   fire_o
);

  logic                   held_q, held_d;
  logic [DELAY_WIDTH-1:0] count_q, count_d;
  logic [DELAY_WIDTH-1:0] count_dec;

  always_comb begin
    count_dec = count_q - 1'b1;
    fire_o    = 1'b0;
    held_d    = held_q;
    count_d   = count_q;
    if (down_i) begin
      if (!held_q) begin
        held_d  = 1'b1;
        count_d = initial_delay_i;
        fire_o  = 1'b1;
      end else if (count_q != '0) begin
        if (count_dec == '0) begin
          count_d = interval_i;
          fire_o  = 1'b1;
        end else begin
          count_d = count_dec;
        end
      end
    end else begin
      held_d  = 1'b0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      count_q <= '0;
    end else if (step_i) begin
      held_q  <= held_d;
      count_q <= count_d;
    end
  end

endmodule

[hdl/key_double_click_auto_repeat.sv]
`timescale 1ns / 1ps
// Ticks pass the input register, then the output register, to give results.
// Throughput: one tick per cycle; while a result stalls the input register
// takes one more tick, then the tick channel stalls until the result is taken.
// Reset clears all key state and both pipeline stages and restores the
// registers to window 30, initial delay 50 and repeat interval 10.
// ----------------------------------------------------------------------------
// Key click decoder top level
// Double-click detection for keys 3 and 4, auto-repeat for keys 1 and 2.
// ----------------------------------------------------------------------------
module key_double_click_auto_repeat #(
  parameter int unsigned DELAY_WIDTH = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  kdcar_stream_if.sink                      tick_i,
  kdcar_stream_if.source                    result_o,
  input  logic                              cfg_we_i,
  input  logic [kdcar_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [DELAY_WIDTH-1:0]            cfg_wdata_i
);

  logic [DELAY_WIDTH-1:0] window_q;
  logic [DELAY_WIDTH-1:0] initial_delay_q;
  logic [DELAY_WIDTH-1:0] interval_q;

  logic               s1_valid_q;
  kdcar_pkg::tick_t   s1_tick_q;
  logic               out_valid_q;
  kdcar_pkg::result_t out_q;
  kdcar_pkg::result_t result_d;

  logic s2_ready;
  logic s1_adv;
  logic tick_accept;

  assign s2_ready    = !out_valid_q || result_o.ready;
  assign s1_adv      = s1_valid_q && s2_ready;
  assign tick_i.ready = !s1_valid_q || s2_ready;
  assign tick_accept = tick_i.valid && tick_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q        <= DELAY_WIDTH'(kdcar_pkg::RST_DOUBLE_CLICK_WINDOW);
      initial_delay_q <= DELAY_WIDTH'(kdcar_pkg::RST_INITIAL_REPEAT_DELAY);
      interval_q      <= DELAY_WIDTH'(kdcar_pkg::RST_REPEAT_INTERVAL);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kdcar_pkg::CFG_DOUBLE_CLICK_WINDOW:  window_q        <= cfg_wdata_i;
        kdcar_pkg::CFG_INITIAL_REPEAT_DELAY: initial_delay_q <= cfg_wdata_i;
        kdcar_pkg::CFG_REPEAT_INTERVAL:      interval_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  kdcar_click #(.DELAY_WIDTH(DELAY_WIDTH)) u_click3 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .press_i  (s1_tick_q.key3_short_press),
    .window_i (window_q),
    .single_o (result_d.key3_single_click),
    .double_o (result_d.key3_double_click)
  );

  kdcar_click #(.DELAY_WIDTH(DELAY_WIDTH)) u_click4 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .press_i  (s1_tick_q.key4_short_press),
    .window_i (window_q),
    .single_o (result_d.key4_single_click),
    .double_o (result_d.key4_double_click)
  );

  kdcar_repeat #(.DELAY_WIDTH(DELAY_WIDTH)) u_repeat1 (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (s1_adv),
    .down_i          (s1_tick_q.key1_down),
    .initial_delay_i (initial_delay_q),
    .interval_i      (interval_q),
    .fire_o          (result_d.key1_fire)
  );

  kdcar_repeat #(.DELAY_WIDTH(DELAY_WIDTH)) u_repeat2 (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (s1_adv),
    .down_i          (s1_tick_q.key2_down),
    .initial_delay_i (initial_delay_q),
    .interval_i      (interval_q),
    .fire_o          (result_d.key2_fire)
  );

  assign result_d.any_event = result_d.key1_fire | result_d.key2_fire |
                              result_d.key3_single_click | result_d.key3_double_click |
                              result_d.key4_single_click | result_d.key4_double_click;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (tick_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_accept) begin
      s1_tick_q <= tick_i.payload;
    end
    if (s1_adv) begin
      out_q <= result_d;
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

endmodule

[hdl/kdcar_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key click decoder port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
module kdcar_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input kdcar_pkg::result_t out_payload_i
);

  a_any_event_is_or: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_payload_i.any_event ==
      (out_payload_i.key1_fire || out_payload_i.key2_fire ||
       out_payload_i.key3_single_click || out_payload_i.key3_double_click ||
       out_payload_i.key4_single_click || out_payload_i.key4_double_click))
  ) else $error("any_event does not match the individual actions");

  a_key3_one_click_kind: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_payload_i.key3_single_click && out_payload_i.key3_double_click)
  ) else $error("key 3 single and double click in one result");

  a_key4_one_click_kind: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_payload_i.key4_single_click && out_payload_i.key4_double_click)
  ) else $error("key 4 single and double click in one result");

  a_stall_holds_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_payload_i))
  ) else $error("stalled result changed");

endmodule

bind key_double_click_auto_repeat kdcar_checker u_kdcar_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .out_payload_i (result_o.payload)
);

[dv/kdcar_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key click decoder scoreboard
// Watches the tick, result and register ports, keeps its own copy of the
// click and auto-repeat state, and compares every result with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module kdcar_scoreboard #(
  parameter int unsigned DELAY_WIDTH = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              tick_valid_i,
  input  logic                              tick_ready_i,
  input  kdcar_pkg::tick_t                  tick_i,
  input  logic                              result_valid_i,
  input  logic                              result_ready_i,
  input  kdcar_pkg::result_t                result_i,
  input  logic                              cfg_we_i,
  input  logic [kdcar_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [DELAY_WIDTH-1:0]            cfg_wdata_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                checked_o
);

  localparam int unsigned NUM_FIELDS = $bits(kdcar_pkg::result_t);

  logic [DELAY_WIDTH-1:0] window_q;
  logic [DELAY_WIDTH-1:0] first_delay_q;
  logic [DELAY_WIDTH-1:0] interval_q;

  logic                            click_armed   [2];
  logic [kdcar_pkg::ELAPSED_W-1:0] click_elapsed [2];
  logic                   key_held  [2];
  logic [DELAY_WIDTH-1:0] key_count [2];

  kdcar_pkg::result_t pending_results[$];

  string field_name [NUM_FIELDS] = '{
    "key1_fire", "key2_fire", "key3_single_click", "key3_double_click",
    "key4_single_click", "key4_double_click", "any_event"
  };

  task automatic click_step(input int k, input logic press,
                            output logic single, output logic dbl);
    single = 1'b0;
    dbl    = 1'b0;
    if (click_armed[k]) begin
      if (click_elapsed[k] != kdcar_pkg::ELAPSED_MAX) begin
        click_elapsed[k] = click_elapsed[k] + 1'b1;
      end
      if (int'(click_elapsed[k]) > int'(window_q)) begin
        single         = 1'b1;
        click_armed[k] = 1'b0;
      end
    end
    if (press) begin
      if (click_armed[k]) begin
        dbl            = 1'b1;
        click_armed[k] = 1'b0;
      end else begin
        click_armed[k]   = 1'b1;
        click_elapsed[k] = '0;
      end
    end
  endtask

  task automatic repeat_step(input int k, input logic down, output logic fire);
    fire = 1'b0;
    if (down) begin
      if (!key_held[k]) begin
        key_held[k]  = 1'b1;
        key_count[k] = first_delay_q;
        fire         = 1'b1;
      end else if (key_count[k] != '0) begin
        key_count[k] = key_count[k] - 1'b1;
        if (key_count[k] == '0) begin
          key_count[k] = interval_q;
          fire         = 1'b1;
        end
      end
    end else begin
      key_held[k]  = 1'b0;
      key_count[k] = '0;
    end
  endtask

  task automatic decode_tick(input kdcar_pkg::tick_t t, output kdcar_pkg::result_t r);
    click_step(0, t.key3_short_press, r.key3_single_click, r.key3_double_click);
    click_step(1, t.key4_short_press, r.key4_single_click, r.key4_double_click);
    repeat_step(0, t.key1_down, r.key1_fire);
    repeat_step(1, t.key2_down, r.key2_fire);
    r.any_event = r.key1_fire | r.key2_fire | r.key3_single_click |
                  r.key3_double_click | r.key4_single_click | r.key4_double_click;
  endtask

  task automatic compare_result(input kdcar_pkg::result_t got);
    kdcar_pkg::result_t exp;
    string   diffs;
    if (pending_results.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10) $display("unexpected result %b with nothing predicted", got);
    end else begin
      exp = pending_results.pop_front();
      checked_o++;
      if (got !== exp) begin
        fail_count_o++;
        if (fail_count_o <= 10) begin
          diffs = "";
          for (int b = 0; b < NUM_FIELDS; b++) begin
            if (got[NUM_FIELDS-1-b] !== exp[NUM_FIELDS-1-b]) begin
              diffs = {diffs, " ", field_name[b]};
            end
          end
          $display("result %0d mismatch: expected %b, actual %b, fields:%s",
                   checked_o, exp, got, diffs);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    kdcar_pkg::result_t r;
    if (!rst_ni) begin
      window_q      <= DELAY_WIDTH'(kdcar_pkg::RST_DOUBLE_CLICK_WINDOW);
      first_delay_q <= DELAY_WIDTH'(kdcar_pkg::RST_INITIAL_REPEAT_DELAY);
      interval_q    <= DELAY_WIDTH'(kdcar_pkg::RST_REPEAT_INTERVAL);
      for (int k = 0; k < 2; k++) begin
        click_armed[k]   = 1'b0;
        click_elapsed[k] = '0;
        key_held[k]      = 1'b0;
        key_count[k]     = '0;
      end
      pending_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          kdcar_pkg::CFG_DOUBLE_CLICK_WINDOW:  window_q      <= cfg_wdata_i;
          kdcar_pkg::CFG_INITIAL_REPEAT_DELAY: first_delay_q <= cfg_wdata_i;
          kdcar_pkg::CFG_REPEAT_INTERVAL:      interval_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (tick_valid_i && tick_ready_i) begin
        decode_tick(tick_i, r);
        pending_results.push_back(r);
      end
      if (result_valid_i && result_ready_i) compare_result(result_i);
      pending_o = pending_results.size();
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key click decoder testbench
// Drives tick transactions through directed and randomized key sequences
// under several register settings, with random gaps on both channels, a long
// result back-pressure stretch and a full drain, and reports the verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned DELAY_W = 8;
  localparam logic [kdcar_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int HOLD_OFF_CYCLES = 200;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we;
  logic [kdcar_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [DELAY_W-1:0] cfg_wdata;

  bit no_idle;
  bit hold_off_req;
  int ticks_sent;
  int settings_used;
  int fail_count;
  int pending;
  int checked;

  kdcar_stream_if #(.payload_t(kdcar_pkg::tick_t))   tick_ch ();
  kdcar_stream_if #(.payload_t(kdcar_pkg::result_t)) result_ch ();

  always #5 clk_i = ~clk_i;

  key_double_click_auto_repeat #(
    .DELAY_WIDTH (DELAY_W)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick_ch),
    .result_o    (result_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  kdcar_scoreboard #(
    .DELAY_WIDTH (DELAY_W)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_valid_i   (tick_ch.valid),
    .tick_ready_i   (tick_ch.ready),
    .tick_i         (tick_ch.payload),
    .result_valid_i (result_ch.valid),
    .result_ready_i (result_ch.ready),
    .result_i       (result_ch.payload),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", pending);
    $display("Verification failed");
    $finish;
  end

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req    = 1'b0;
        result_ch.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
      end
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        result_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      result_ch.ready = 1'b1;
      do @(posedge clk_i); while (!result_ch.valid);
      @(negedge clk_i);
    end
  end

  task automatic send_tick(input kdcar_pkg::tick_t t);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    @(negedge clk_i);
    if (gap > 0) begin
      tick_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tick_ch.valid   = 1'b1;
    tick_ch.payload = t;
    do @(posedge clk_i); while (!tick_ch.ready);
    ticks_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    tick_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [kdcar_pkg::CFG_IDX_W-1:0] idx,
                           input logic [DELAY_W-1:0] value);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  task automatic apply_setting(input int window, input int first_delay, input int interval);
    drain();
    write_reg(kdcar_pkg::CFG_DOUBLE_CLICK_WINDOW, DELAY_W'(window));
    write_reg(kdcar_pkg::CFG_INITIAL_REPEAT_DELAY, DELAY_W'(first_delay));
    write_reg(kdcar_pkg::CFG_REPEAT_INTERVAL, DELAY_W'(interval));
    settings_used++;
  endtask

  // held levels toggle rarely so repeats get reached; presses at random, 1 in press_div
  task automatic run_random(input int n, input int press_div, input int hold_div,
                            input bit with_hold_off, input bit with_pause);
    logic  k1, k2;
    kdcar_pkg::tick_t t;
    k1 = 1'b0;
    k2 = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, hold_div - 1) == 0) k1 = ~k1;
      if ($urandom_range(0, hold_div - 1) == 0) k2 = ~k2;
      t.key1_down        = k1;
      t.key2_down        = k2;
      t.key3_short_press = ($urandom_range(0, press_div - 1) == 0);
      t.key4_short_press = ($urandom_range(0, press_div - 1) == 0);
      if ($urandom_range(0, 29) == 0) t = kdcar_pkg::tick_t'(4'($urandom_range(0, 15)));
      if (with_hold_off && i == n / 3) hold_off_req = 1'b1;
      if (with_pause && i == n / 2) drain();
      send_tick(t);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    logic [3:0] directed [] = '{
      4'b0000, 4'b0010, 4'b0010, 4'b0001, 4'b0000, 4'b0000, 4'b0001, 4'b0000,
      4'b0000, 4'b0000, 4'b0011, 4'b0011, 4'b1000, 4'b1000, 4'b1000, 4'b1000,
      4'b1000, 4'b1000, 4'b0100, 4'b1110, 4'b1111, 4'b0000, 4'b1111, 4'b0000
    };
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = kdcar_pkg::CFG_DOUBLE_CLICK_WINDOW;
    cfg_wdata       = '0;
    tick_ch.valid   = 1'b0;
    tick_ch.payload = '0;
    no_idle         = 1'b0;
    hold_off_req    = 1'b0;
    ticks_sent      = 0;
    settings_used   = 1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_random(150, 8, 60, 1'b0, 1'b0);

    apply_setting(2, 3, 2);
    foreach (directed[i]) send_tick(kdcar_pkg::tick_t'(directed[i]));

    apply_setting(0, 0, 0);
    run_random(120, 4, 10, 1'b0, 1'b0);
    apply_setting(255, 255, 255);
    run_random(500, 150, 400, 1'b0, 1'b0);
    apply_setting(1, 1, 1);
    run_random(150, 3, 12, 1'b1, 1'b0);
    apply_setting(0, 7, 0);
    run_random(120, 5, 20, 1'b0, 1'b1);
    apply_setting(9, 0, 3);
    run_random(120, 6, 20, 1'b0, 1'b0);
    for (int s = 0; s < 3; s++) begin
      apply_setting($urandom_range(0, 40), $urandom_range(0, 60), $urandom_range(0, 20));
      if (s == 1) write_reg(CFG_UNUSED_IDX, DELAY_W'($urandom_range(0, 255)));
      run_random(120, $urandom_range(3, 20), $urandom_range(20, 100), 1'b0, 1'b0);
    end

    drain();
    repeat (10) @(negedge clk_i);
    $display("Covered %0d tick transactions over %0d register settings", ticks_sent,
             settings_used);
    $display("%0d results checked, %0d mismatches, %0d outstanding", checked, fail_count,
             pending);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
